FILE: hw/rtl/mexp_pkg.sv
// mexp_pkg: shared types and constants for the modular exponentiation unit
// controller states, datapath operation codes, command and status structs
// no dependencies

package mexp_pkg;

	localparam int WORD_BITS_DEF = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RED_GO,
		ST_WAIT,
		ST_CHECK,
		ST_ENDP,
		ST_FIN
	} mexp_state_t;

	// modular multiply unit jobs: reduce a value, multiply into acc, square
	typedef enum logic [1:0] {
		OP_RED,
		OP_MUL,
		OP_SQR
	} mexp_op_t;

	typedef struct packed {
		logic     load;
		logic     start;
		mexp_op_t op;
		logic     phase2;
		logic     finish;
	} mexp_cmd_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic exp_zero;
		logic exp_lsb;
		logic phase1;
		logic bad;
	} mexp_stat_t;

endpackage

FILE: hw/rtl/mexp_mmul.sv
// mexp_mmul: bit-serial modular multiplier, r = (a * b) mod m, one bit of b per cycle
// requires m >= 1 and a <= m; b may hold any value
// depends on mexp_pkg (default width)

module mexp_mmul #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [WORD_BITS-1:0] a,
	input  logic [WORD_BITS-1:0] b,
	input  logic [WORD_BITS-1:0] m,
	output logic                 busy,
	output logic                 done,
	output logic [WORD_BITS-1:0] r
);

	localparam int CW = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] a_q, b_q, m_q, r_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q, done_q;
	logic [WORD_BITS+1:0] t, m1, m2;
	logic [WORD_BITS+1:0] r_next;

	// horner step: t = 2r + bit*a < 3m, then subtract m or 2m
	always_comb begin
		t  = {1'b0, r_q, 1'b0} + {2'b00, (b_q[WORD_BITS-1] ? a_q : '0)};
		m1 = {2'b00, m_q};
		m2 = {1'b0, m_q, 1'b0};
		if (t >= m2) begin
			r_next = t - m2;
		end else if (t >= m1) begin
			r_next = t - m1;
		end else begin
			r_next = t;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(WORD_BITS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			m_q <= m;
			r_q <= '0;
		end else if (busy_q) begin
			b_q <= {b_q[WORD_BITS-2:0], 1'b0};
			r_q <= r_next[WORD_BITS-1:0];
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign r    = r_q;

endmodule

FILE: hw/rtl/mexp_dp.sv
// mexp_dp: operand registers, exponent shifter and result register
// runs square-and-multiply jobs on one shared mexp_mmul
// depends on mexp_pkg, mexp_mmul

module mexp_dp #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mexp_pkg::mexp_cmd_t   cmd,
	input  logic                  action,
	input  logic [WORD_BITS-1:0]  base,
	input  logic [WORD_BITS-1:0]  exponent,
	input  logic [WORD_BITS-1:0]  modulus,
	output mexp_pkg::mexp_stat_t  st,
	output logic [WORD_BITS-1:0]  result,
	output logic                  error
);

	logic [WORD_BITS-1:0] base_q, m_q, mod_q, exp_q, acc_q, sq_q;
	logic [WORD_BITS-1:0] res_q;
	logic                 err_q, phase1_q, error_q;
	mexp_pkg::mexp_op_t   op_q;
	logic                 in_bad;
	logic [WORD_BITS-1:0] op_a, op_b, eff;
	logic                 u_busy, u_done;
	logic [WORD_BITS-1:0] u_r;

	assign in_bad = action ? (modulus < WORD_BITS'(2)) : (modulus == '0);
	assign eff    = (mod_q == WORD_BITS'(1)) ? '0 : acc_q;

	always_comb begin
		case (cmd.op)
			mexp_pkg::OP_RED: begin
				op_a = WORD_BITS'(1);
				op_b = phase1_q ? WORD_BITS'(2) : base_q;
			end
			mexp_pkg::OP_MUL: begin
				op_a = acc_q;
				op_b = sq_q;
			end
			mexp_pkg::OP_SQR: begin
				op_a = sq_q;
				op_b = sq_q;
			end
			default: begin
				op_a = sq_q;
				op_b = sq_q;
			end
		endcase
	end

	mexp_mmul #(
		.WORD_BITS(WORD_BITS)
	) u_mmul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.start),
		.a     (op_a),
		.b     (op_b),
		.m     (mod_q),
		.busy  (u_busy),
		.done  (u_done),
		.r     (u_r)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			base_q   <= base;
			m_q      <= modulus;
			mod_q    <= action ? (modulus - WORD_BITS'(1)) : modulus;
			exp_q    <= exponent;
			acc_q    <= WORD_BITS'(1);
			phase1_q <= action;
			err_q    <= in_bad;
		end else if (cmd.phase2) begin
			mod_q    <= m_q;
			exp_q    <= eff;
			acc_q    <= WORD_BITS'(1);
			phase1_q <= 1'b0;
		end else if (u_done) begin
			case (op_q)
				mexp_pkg::OP_RED: sq_q <= u_r;
				mexp_pkg::OP_MUL: begin
					acc_q    <= u_r;
					exp_q[0] <= 1'b0;
				end
				mexp_pkg::OP_SQR: begin
					sq_q  <= u_r;
					exp_q <= {1'b0, exp_q[WORD_BITS-1:1]};
				end
				default: sq_q <= u_r;
			endcase
		end
		if (cmd.start) begin
			op_q <= cmd.op;
		end
		if (cmd.finish) begin
			res_q   <= err_q ? '0 : acc_q;
			error_q <= err_q;
		end
	end

	assign st.busy     = u_busy;
	assign st.done     = u_done;
	assign st.exp_zero = (exp_q == '0);
	assign st.exp_lsb  = exp_q[0];
	assign st.phase1   = phase1_q;
	assign st.bad      = err_q;

	assign result = res_q;
	assign error  = error_q;

endmodule

FILE: hw/rtl/mexp_ctrl.sv
// mexp_ctrl: sequencing state machine and output valid register
// steps reduce, multiply and square jobs through the datapath, two phases in action 1
// depends on mexp_pkg

module mexp_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  logic                 out_stall,
	input  mexp_pkg::mexp_stat_t st,
	output mexp_pkg::mexp_cmd_t  cmd
);

	mexp_pkg::mexp_state_t state_q, state_d;
	logic                  out_valid_q;
	logic                  out_free;

	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mexp_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.op  = mexp_pkg::OP_RED;
		unique case (state_q)
			mexp_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = mexp_pkg::ST_RED_GO;
				end
			end
			mexp_pkg::ST_RED_GO: begin
				if (st.bad) begin
					state_d = mexp_pkg::ST_FIN;
				end else begin
					cmd.start = 1'b1;
					cmd.op    = mexp_pkg::OP_RED;
					state_d   = mexp_pkg::ST_WAIT;
				end
			end
			mexp_pkg::ST_WAIT: begin
				if (st.done) begin
					state_d = mexp_pkg::ST_CHECK;
				end
			end
			mexp_pkg::ST_CHECK: begin
				if (st.exp_zero) begin
					state_d = mexp_pkg::ST_ENDP;
				end else begin
					cmd.start = 1'b1;
					cmd.op    = st.exp_lsb ? mexp_pkg::OP_MUL : mexp_pkg::OP_SQR;
					state_d   = mexp_pkg::ST_WAIT;
				end
			end
			mexp_pkg::ST_ENDP: begin
				if (st.phase1) begin
					cmd.phase2 = 1'b1;
					state_d    = mexp_pkg::ST_RED_GO;
				end else begin
					state_d = mexp_pkg::ST_FIN;
				end
			end
			mexp_pkg::ST_FIN: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_d    = mexp_pkg::ST_IDLE;
				end
			end
			default: state_d = mexp_pkg::ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != mexp_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTH
	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while stalled");

	// the shared unit takes a new job only when free
	a_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !st.busy)
		else $error("multiply unit started while busy");

	// job completion is only seen while waiting for it
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		st.done |-> (state_q == mexp_pkg::ST_WAIT))
		else $error("unit done outside wait state");

	// a started job keeps the unit busy on the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> st.busy)
		else $error("unit not busy after start");
`endif

endmodule

FILE: hw/rtl/modular_exponentiation_32_unit.sv
// modular_exponentiation_32_unit: top level, base^e mod modulus by square-and-multiply
// depends on mexp_pkg, mexp_ctrl, mexp_dp (which holds mexp_mmul)
//
//   channel   signals                                    dir
//   in        in_valid/in_stall, action base exponent modulus   in
//   out       out_valid/out_stall, result error                  out
//
// every modular multiply is one bit-serial pass of the shared multiplier
// action 0: one reduction plus one square per exponent bit below the top set bit and one
//   multiply per set bit, up to 64 jobs at 32 bits
// action 1: the same again first for 2^k mod (modulus-1), so up to about twice that
// one item at a time; in_stall stays high until the result is in the output register
// a result waiting under out_stall holds the next item at its last cycle
// arst_n clears the state machine and the output valid; no clearing pass

module modular_exponentiation_32_unit #(
	parameter int WORD_BITS = mexp_pkg::WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic                 action,
	input  logic [WORD_BITS-1:0] base,
	input  logic [WORD_BITS-1:0] exponent,
	input  logic [WORD_BITS-1:0] modulus,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [WORD_BITS-1:0] result,
	output logic                 error
);

	mexp_pkg::mexp_cmd_t  cmd;
	mexp_pkg::mexp_stat_t st;

	mexp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.st       (st),
		.cmd      (cmd)
	);

	mexp_dp #(
		.WORD_BITS(WORD_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.action  (action),
		.base    (base),
		.exponent(exponent),
		.modulus (modulus),
		.st      (st),
		.result  (result),
		.error   (error)
	);

endmodule
